// ===== hdl/signed_decimal_seven_segment_driver_unit_defines.svh =====
// Assertion macros used by the queue RTL file.
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_DRIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition on every clock edge outside reset.
`define SDSD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sdsd check failed");
// Check that a condition implies another in the same cycle.
`define SDSD_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdsd check failed");
// Check that a condition implies another in the next cycle.
`define SDSD_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdsd check failed");
`else
`define SDSD_ASSERT(lbl, clk, rstn, prop)
`define SDSD_IMPLIES(lbl, clk, rstn, ante, cons)
`define SDSD_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/sdsd_pkg.sv =====
package sdsd_pkg;

    localparam int MAG_W  = 32;                    // magnitude width, holds 2^31
    localparam int CNT_W  = 4;                     // digit count width
    localparam int CODE_W = 4;
    localparam int SEG_W  = 7;
    localparam int OUT_POS = 8;                    // positions carried by the ports

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/sdsd_front.sv =====
module sdsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_value,
    output logic                  o_push,
    output sdsd_pkg::t_item       o_item,
    input  sdsd_pkg::t_q_stat     i_stat
);
    import sdsd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_push  = r_valid && !i_stat.full;
    assign o_stall = r_valid && i_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    // Split sign and magnitude; the most negative value wraps to 2^31.
    always_comb begin
        n_item.neg = i_value[31];
        n_item.mag = i_value[31] ? MAG_W'(~i_value + 32'sd1) : MAG_W'(i_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/sdsd_queue.sv =====
`include "signed_decimal_seven_segment_driver_unit_defines.svh"

module sdsd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sdsd_pkg::t_item       i_item,
    input  logic                  i_pop,
    output sdsd_pkg::t_item       o_item,
    output sdsd_pkg::t_q_stat     o_stat
);
    import sdsd_pkg::*;

    localparam logic [QCW-1:0] CNT_FULL = QCW'(QDEPTH);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    `SDSD_IMPLIES(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SDSD_IMPLIES(a_push_not_full, i_clk, i_rst_n, i_push, r_count != CNT_FULL)
    `SDSD_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCW'(1))

endmodule

// ===== hdl/sdsd_back.sv =====
module sdsd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [sdsd_pkg::CNT_W-1:0] i_digits,
    input  sdsd_pkg::t_q_stat     i_stat,
    input  sdsd_pkg::t_item       i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_symbol_codes,
    output logic [55:0]           o_segment_pattern,
    output logic                  o_overflow
);
    import sdsd_pkg::*;

    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_BITS  = 4;
    localparam int STAGES     = MAG_W / STEP_BITS;

    localparam logic [CODE_W-1:0] SYM_MINUS = 4'd10;
    localparam logic [CODE_W-1:0] SYM_BLANK = 4'd11;

    // Segment bits: 0 top, 1 upper left, 2 upper right, 3 middle,
    // 4 lower left, 5 lower right, 6 bottom.
    function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:      seg = 7'h77;
            4'd1:      seg = 7'h24;
            4'd2:      seg = 7'h5D;
            4'd3:      seg = 7'h6D;
            4'd4:      seg = 7'h2E;
            4'd5:      seg = 7'h6B;
            4'd6:      seg = 7'h7B;
            4'd7:      seg = 7'h25;
            4'd8:      seg = 7'h7F;
            4'd9:      seg = 7'h6F;
            SYM_MINUS: seg = 7'h08;
            default:   seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Four shift-and-add-3 steps, MSB of bits first.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
                                                input logic [STEP_BITS-1:0] bits);
        logic [BCD_W-1:0] bcd;
        bcd = bcd_in;
        for (int s = STEP_BITS - 1; s >= 0; s--) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bits[s]};
        end
        return bcd;
    endfunction

    logic             r_vld [STAGES];
    logic             r_neg [STAGES];
    logic [BCD_W-1:0] r_bcd [STAGES];
    logic [MAG_W-1:0] r_bin [STAGES-1];
    logic [BCD_W-1:0] n_bcd [STAGES];
    logic [MAG_W-1:0] n_bin [STAGES-1];

    logic             r_out_valid;
    logic [31:0]      r_codes;
    logic [55:0]      r_segs;
    logic             r_ovf;
    logic [31:0]      n_codes;
    logic [55:0]      n_segs;
    logic             n_ovf;

    logic             adv;
    logic [CNT_W-1:0] nd;
    logic [BCD_W-1:0] fin_bcd;
    logic             fin_neg;
    logic [CODE_W-1:0] sym;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_stat.empty;

    always_comb begin
        n_bcd[0] = dabble('0, i_item.mag[MAG_W-1 -: STEP_BITS]);
        n_bin[0] = i_item.mag << STEP_BITS;
        for (int k = 1; k < STAGES; k++) begin
            n_bcd[k] = dabble(r_bcd[k-1], r_bin[k-1][MAG_W-1 -: STEP_BITS]);
        end
        for (int k = 1; k < STAGES - 1; k++) begin
            n_bin[k] = r_bin[k-1] << STEP_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= o_pop;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_neg[0] <= i_item.neg;
            for (int k = 1; k < STAGES; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_bcd[k] <= n_bcd[k];
            end
            for (int k = 0; k < STAGES - 1; k++) begin
                r_bin[k] <= n_bin[k];
            end
        end
    end

    // Lay out the row: digits, minus (not on overflow), blanks.
    always_comb begin
        fin_bcd = r_bcd[STAGES-1];
        fin_neg = r_neg[STAGES-1];
        nd = CNT_W'(1);
        for (int d = 1; d < BCD_DIGITS; d++) begin
            if (fin_bcd[4*d +: 4] != 4'd0) begin
                nd = CNT_W'(d + 1);
            end
        end
        n_ovf = (nd > i_digits) || (fin_neg && (nd == i_digits));
        n_codes = '0;
        n_segs  = '0;
        for (int p = 0; p < OUT_POS; p++) begin
            if ((CNT_W'(p) < nd) && (CNT_W'(p) < i_digits)) begin
                sym = fin_bcd[4*p +: 4];
            end else if (!n_ovf && fin_neg && (CNT_W'(p) == nd)) begin
                sym = SYM_MINUS;
            end else begin
                sym = SYM_BLANK;
            end
            n_codes[CODE_W*p +: CODE_W] = sym;
            n_segs[SEG_W*p +: SEG_W]    = seg_of(sym);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_codes <= n_codes;
            r_segs  <= n_segs;
            r_ovf   <= n_ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_symbol_codes    = r_codes;
    assign o_segment_pattern = r_segs;
    assign o_overflow        = r_ovf;

endmodule

// ===== hdl/signed_decimal_seven_segment_driver_unit.sv =====
// An input beat passes the front register, the queue, eight conversion
// stages and the output register. Throughput: one beat per cycle while
// i_stall is low; the eight-stage binary-to-decimal pipeline takes a new
// magnitude each cycle and the output register sets the pace.
// Reset (synchronous, active low) empties the queue and pipeline and sets
// the digit count to eight, or to MAX_DIGITS when that is smaller.
module signed_decimal_seven_segment_driver_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_value,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_symbol_codes,
    output logic [55:0]         o_segment_pattern,
    output logic                o_overflow,
    // digit count register
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata
);
    import sdsd_pkg::*;

    localparam logic [CNT_W-1:0] DIG_MAX   = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] DIG_RESET = CNT_W'((MAX_DIGITS < 8) ? MAX_DIGITS : 8);

    logic [CNT_W-1:0] r_digits;
    logic [CNT_W-1:0] n_digits;

    logic    push;
    logic    pop;
    t_item   front_item;
    t_item   queue_item;
    t_q_stat q_stat;

    // Saturate the count on write: zero shows one position, too many shows
    // MAX_DIGITS positions.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_digits = CNT_W'(1);
        end else if (i_cfg_wdata > DIG_MAX) begin
            n_digits = DIG_MAX;
        end else begin
            n_digits = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= DIG_RESET;
        end else if (i_cfg_we) begin
            r_digits <= n_digits;
        end
    end

    // Front: take the beat, split sign and magnitude.
    sdsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (push),
        .o_item  (front_item),
        .i_stat  (q_stat)
    );

    // Queue: decouple the front from a stalled back end.
    sdsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (q_stat)
    );

    // Back: convert to decimal digits, lay out the row, hold the result.
    sdsd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_digits          (r_digits),
        .i_stat            (q_stat),
        .i_item            (queue_item),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_symbol_codes    (o_symbol_codes),
        .o_segment_pattern (o_segment_pattern),
        .o_overflow        (o_overflow)
    );

endmodule
